// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// Property must never hold at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) not (prop)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, prop)
`endif

`endif

// ===== rtl/bdlp_pkg.sv =====
// ----------------------------------------------------------------------------
// bdlp_pkg
// Types and constants of the button debounce / long-press block.
// ----------------------------------------------------------------------------
package bdlp_pkg;

  localparam int unsigned Buttons = 3;
  localparam int unsigned BtnW    = 2;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgW    = 16;

  localparam logic [15:0] BounceReset = 16'd100;
  localparam logic [15:0] LimitReset  = 16'd2000;

  typedef enum logic [0:0] {
    RegBounce = 1'b0,
    RegLimit  = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    EvShort   = 2'd0,
    EvLong    = 2'd1,
    EvRelease = 2'd2
  } ev_kind_e;

  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhArmed   = 2'd1,
    PhPressed = 2'd2
  } phase_e;

  typedef struct packed {
    logic [Buttons-1:0] pressed_mask;
    logic [TimeW-1:0]   now_ms;
  } tick_t;

  typedef struct packed {
    logic [BtnW-1:0] button;
    logic [1:0]      event_kind;
    logic            last_of_tick;
  } event_t;

  // one state RAM entry per button
  typedef struct packed {
    phase_e           phase;
    logic [TimeW-1:0] start_time;
  } entry_t;

endpackage

// ===== rtl/bdlp_in_if.sv =====
// ----------------------------------------------------------------------------
// bdlp_in_if
// Valid/ready channel that carries one tick.
// ----------------------------------------------------------------------------
interface bdlp_in_if;
  import bdlp_pkg::*;

  logic  valid;
  logic  ready;
  tick_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bdlp_ev_if.sv =====
// ----------------------------------------------------------------------------
// bdlp_ev_if
// Valid/ready channel that carries one button event.
// ----------------------------------------------------------------------------
interface bdlp_ev_if;
  import bdlp_pkg::*;

  logic   valid;
  logic   ready;
  event_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/button_debounce_long_press.sv =====
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Per-button debounce with short-press, long-press and release events.
// ----------------------------------------------------------------------------
// One tick (pressed mask plus millisecond time) is taken while the block is
// idle. Button states sit in a small state RAM; each button costs one
// read-modify-write step, a button that emits both a short press and a
// release takes one more step, and a closing step ends the tick; the event
// sink can stall any step that emits an event. Events leave one per cycle in
// button order while the sink does not stall, the final one of a tick
// flagged with last_of_tick; one event is held back until the next is known
// so that flag can be set. Entries carry a valid bit that reset clears, so
// no clearing pass follows reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module button_debounce_long_press (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [bdlp_pkg::CfgW-1:0] cfg_data_i,
  bdlp_in_if.sink                   in_i,
  bdlp_ev_if.source                 ev_o
);
  import bdlp_pkg::*;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_SEC,
    S_FLUSH
  } state_e;

  state_e              st_q, st_d;
  logic [BtnW-1:0]     btn_q, btn_d;
  logic [Buttons-1:0]  mask_q, mask_d;
  logic [TimeW-1:0]    now_q, now_d;
  logic [CfgW-1:0]     bounce_q, bounce_d;
  logic [CfgW-1:0]     limit_q, limit_d;
  logic [Buttons-1:0]  valid_q, valid_d;
  logic                rd_vld_q, rd_vld_d;
  logic                pend_vld_q, pend_vld_d;
  logic [BtnW-1:0]     pend_btn_q, pend_btn_d;
  ev_kind_e            pend_kind_q, pend_kind_d;
  logic                out_vld_q, out_vld_d;
  event_t              out_q, out_d;

  logic                ram_we, ram_re;
  logic [BtnW-1:0]     ram_raddr;
  entry_t              ram_wdata;
  logic [EntryW-1:0]   ram_rdata;

  entry_t              cur, nxt;
  logic                down, gt_bounce, gt_long;
  logic [TimeW-1:0]    elapsed;
  logic [1:0]          ev_cnt;
  ev_kind_e            first_kind, push_kind;
  logic                can_push, step_ok, push, advance, last_btn, in_acc;

  bdlp_ram #(
    .WIDTH (EntryW),
    .DEPTH (Buttons)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (btn_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // never-written entries read as idle with zero start time
  assign cur       = rd_vld_q ? entry_t'(ram_rdata)
                              : entry_t'{phase: PhIdle, start_time: '0};
  assign down      = mask_q[btn_q];
  assign elapsed   = now_q - cur.start_time;
  assign gt_bounce = elapsed > {{(TimeW-CfgW){1'b0}}, bounce_q};
  assign gt_long   = elapsed > {{(TimeW-CfgW){1'b0}}, limit_q};

  always_comb begin
    nxt        = cur;
    ev_cnt     = 2'd0;
    first_kind = EvRelease;
    if (down) begin
      case (cur.phase)
        PhArmed: begin
          if (gt_bounce) nxt.phase = PhPressed;
        end
        PhPressed: begin
          if (gt_long) begin
            ev_cnt     = 2'd1;
            first_kind = EvLong;
          end
        end
        default: begin
          nxt.phase      = PhArmed;
          nxt.start_time = now_q;
        end
      endcase
    end else begin
      case (cur.phase)
        PhArmed: begin
          if (gt_bounce) begin
            nxt.phase      = PhIdle;
            nxt.start_time = '0;
          end
        end
        PhPressed: begin
          nxt.phase      = PhIdle;
          nxt.start_time = '0;
          if (gt_bounce && !gt_long) begin
            ev_cnt     = 2'd2;
            first_kind = EvShort;
          end else begin
            ev_cnt     = 2'd1;
          end
        end
        default: begin
          nxt.phase = PhIdle;
        end
      endcase
    end
  end

  assign in_acc    = in_i.valid && in_i.ready;
  assign can_push  = !out_vld_q || ev_o.ready;
  assign last_btn  = (btn_q == BtnW'(Buttons - 1));
  assign step_ok   = (st_q == S_LOOK) && ((ev_cnt == 2'd0) || can_push);
  assign push      = ((st_q == S_LOOK) && (ev_cnt != 2'd0) && can_push)
                  || ((st_q == S_SEC) && can_push);
  assign push_kind = (st_q == S_SEC) ? EvRelease : first_kind;
  assign advance   = (step_ok && (ev_cnt != 2'd2)) || ((st_q == S_SEC) && can_push);

  assign ram_we    = step_ok;
  assign ram_wdata = nxt;
  assign ram_re    = in_acc || (advance && !last_btn);
  assign ram_raddr = in_acc ? '0 : BtnW'(btn_q + 1'b1);

  assign in_i.ready = (st_q == S_IDLE);
  assign ev_o.valid = out_vld_q;
  assign ev_o.data  = out_q;

  always_comb begin
    st_d        = st_q;
    btn_d       = btn_q;
    mask_d      = mask_q;
    now_d       = now_q;
    bounce_d    = bounce_q;
    limit_d     = limit_q;
    valid_d     = valid_q;
    rd_vld_d    = rd_vld_q;
    pend_vld_d  = pend_vld_q;
    pend_btn_d  = pend_btn_q;
    pend_kind_d = pend_kind_q;
    out_vld_d   = out_vld_q && !ev_o.ready;
    out_d       = out_q;

    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegBounce: bounce_d = cfg_data_i;
        RegLimit:  limit_d  = cfg_data_i;
        default:   ;
      endcase
    end

    if (ram_re) begin
      rd_vld_d = valid_q[ram_raddr];
    end
    if (ram_we) begin
      valid_d[btn_q] = 1'b1;
    end

    // hand the held event to the output, hold the new one back
    if (push) begin
      if (pend_vld_q) begin
        out_vld_d = 1'b1;
        out_d     = '{button: pend_btn_q, event_kind: pend_kind_q, last_of_tick: 1'b0};
      end
      pend_vld_d  = 1'b1;
      pend_btn_d  = btn_q;
      pend_kind_d = push_kind;
    end

    case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          mask_d = in_i.data.pressed_mask;
          now_d  = in_i.data.now_ms;
          btn_d  = '0;
          st_d   = S_LOOK;
        end
      end
      S_LOOK, S_SEC: begin
        if (step_ok && (ev_cnt == 2'd2)) begin
          st_d = S_SEC;
        end else if (advance) begin
          if (last_btn) begin
            st_d = S_FLUSH;
          end else begin
            btn_d = BtnW'(btn_q + 1'b1);
            st_d  = S_LOOK;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_vld_q) begin
          st_d = S_IDLE;
        end else if (can_push) begin
          out_vld_d  = 1'b1;
          out_d      = '{button: pend_btn_q, event_kind: pend_kind_q, last_of_tick: 1'b1};
          pend_vld_d = 1'b0;
          st_d       = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      btn_q       <= '0;
      mask_q      <= '0;
      now_q       <= '0;
      bounce_q    <= BounceReset;
      limit_q     <= LimitReset;
      valid_q     <= '0;
      rd_vld_q    <= 1'b0;
      pend_vld_q  <= 1'b0;
      pend_btn_q  <= '0;
      pend_kind_q <= EvRelease;
      out_vld_q   <= 1'b0;
      out_q       <= '0;
    end else begin
      st_q        <= st_d;
      btn_q       <= btn_d;
      mask_q      <= mask_d;
      now_q       <= now_d;
      bounce_q    <= bounce_d;
      limit_q     <= limit_d;
      valid_q     <= valid_d;
      rd_vld_q    <= rd_vld_d;
      pend_vld_q  <= pend_vld_d;
      pend_btn_q  <= pend_btn_d;
      pend_kind_q <= pend_kind_d;
      out_vld_q   <= out_vld_d;
      out_q       <= out_d;
    end
  end

  `ASSERT_NEVER(a_idle_no_pend, clk_i, rst_ni, (st_q == S_IDLE) && pend_vld_q)
  `ASSERT_PROP(a_accept_starts_walk, clk_i, rst_ni, in_acc |=> (st_q == S_LOOK) && (btn_q == '0))
  `ASSERT_PROP(a_second_after_first, clk_i, rst_ni, (st_q == S_SEC) |-> pend_vld_q)
  `ASSERT_PROP(a_last_closes_tick, clk_i, rst_ni,
               (st_q == S_FLUSH) && pend_vld_q && can_push |=> (st_q == S_IDLE) && out_q.last_of_tick)

endmodule

// ===== rtl/bdlp_ram.sv =====
// ----------------------------------------------------------------------------
// bdlp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bdlp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/bdlp_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_event_checker
// Watches the tick and event channels of the debounce block, runs its own
// copy of the per-button state machines and compares every event that
// leaves the block, in order, against the predicted event list.
// ----------------------------------------------------------------------------
module bdlp_event_checker
  import bdlp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  bdlp_in_if              tick_i,
  bdlp_ev_if              ev_i,
  output int              errors_o,
  output int              pending_o
);

  phase_e           btn_phase [Buttons];
  logic [TimeW-1:0] btn_start [Buttons];
  logic [CfgW-1:0]  bounce_ms;
  logic [CfgW-1:0]  limit_ms;
  event_t           due_events [$];
  int               errors_q;

  assign errors_o = errors_q;

  function automatic void note_mismatch(string what, event_t want, event_t got);
    errors_q++;
    if (errors_q <= 10) begin
      $display("%0t: %s: button exp %0d got %0d, kind exp %0d got %0d, last exp %0b got %0b",
               $realtime, what, want.button, got.button, want.event_kind, got.event_kind,
               want.last_of_tick, got.last_of_tick);
    end
  endfunction

  // Step every button machine by one tick and queue the events it causes.
  function automatic void advance_buttons(tick_t tick);
    logic [TimeW-1:0] elapsed;
    event_t           evs [2*Buttons];
    int               cnt;
    cnt = 0;
    for (int n = 0; n < Buttons; n++) begin
      elapsed = tick.now_ms - btn_start[n];
      if (tick.pressed_mask[n]) begin
        case (btn_phase[n])
          PhArmed: begin
            if (elapsed > bounce_ms) btn_phase[n] = PhPressed;
          end
          PhPressed: begin
            if (elapsed > limit_ms) begin
              evs[cnt] = '{button: BtnW'(n), event_kind: EvLong, last_of_tick: 1'b0};
              cnt++;
            end
          end
          default: begin
            btn_phase[n] = PhArmed;
            btn_start[n] = tick.now_ms;
          end
        endcase
      end else begin
        case (btn_phase[n])
          PhArmed: begin
            if (elapsed > bounce_ms) begin
              btn_phase[n] = PhIdle;
              btn_start[n] = '0;
            end
          end
          PhPressed: begin
            if (elapsed > bounce_ms && elapsed <= limit_ms) begin
              evs[cnt] = '{button: BtnW'(n), event_kind: EvShort, last_of_tick: 1'b0};
              cnt++;
            end
            btn_phase[n] = PhIdle;
            btn_start[n] = '0;
            evs[cnt] = '{button: BtnW'(n), event_kind: EvRelease, last_of_tick: 1'b0};
            cnt++;
          end
          default: btn_phase[n] = PhIdle;
        endcase
      end
    end
    if (cnt > 0) evs[cnt-1].last_of_tick = 1'b1;
    for (int k = 0; k < cnt; k++) due_events.push_back(evs[k]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    event_t want;
    if (!rst_ni) begin
      for (int n = 0; n < Buttons; n++) begin
        btn_phase[n] = PhIdle;
        btn_start[n] = '0;
      end
      bounce_ms = BounceReset;
      limit_ms  = LimitReset;
      due_events.delete();
      errors_q  = 0;
      pending_o = 0;
    end else begin
      // retire events of the previous tick before predicting a new one
      if (ev_i.valid && ev_i.ready) begin
        if (due_events.size() == 0) begin
          note_mismatch("unexpected event", '0, ev_i.data);
        end else begin
          want = due_events.pop_front();
          if (ev_i.data.button !== want.button ||
              ev_i.data.event_kind !== want.event_kind ||
              ev_i.data.last_of_tick !== want.last_of_tick) begin
            note_mismatch("event mismatch", want, ev_i.data);
          end
        end
      end
      if (tick_i.valid && tick_i.ready) advance_buttons(tick_i.data);
      if (cfg_we_i) begin
        if (cfg_idx_i == RegBounce) bounce_ms = cfg_data_i;
        else limit_ms = cfg_data_i;
      end
      pending_o = due_events.size();
    end
  end

endmodule

// ===== tb/button_debounce_long_press_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_long_press_tb
// Drives ticks into the debounce block under several register settings:
// directed hold/release cases first, then random press sequences with random
// time steps, random gaps and event-side stalls in all but the closing run,
// and one long stall.
module button_debounce_long_press_tb;
  import bdlp_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int LongHold   = 250;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_we;
  logic            cfg_idx;
  logic [CfgW-1:0] cfg_data;

  bdlp_in_if tick_ch ();
  bdlp_ev_if event_ch ();

  int errors;
  int pending;
  int cycle_cnt = 0;

  bit               send_gaps;
  bit               recv_stalls;
  bit               hold_req;
  logic [CfgW-1:0]  bounce_cur;
  logic [CfgW-1:0]  limit_cur;
  logic [TimeW-1:0] now_t;
  logic [Buttons-1:0] held;

  button_debounce_long_press dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (tick_ch),
    .ev_o       (event_ch)
  );

  bdlp_event_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .tick_i     (tick_ch),
    .ev_i       (event_ch),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // event sink: random stalls, plus one long hold on request
  initial begin
    event_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        event_ch.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        event_ch.ready <= 1'b1;
      end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
        event_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        event_ch.ready <= 1'b1;
      end else begin
        event_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_tick(input logic [Buttons-1:0] mask, input logic [TimeW-1:0] stamp);
    bit took;
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.data  <= {mask, stamp};
    // sample ready mid-cycle, the transaction completes at the next edge
    do begin
      @(negedge clk_i);
      took = tick_ch.ready;
      @(posedge clk_i);
    end while (!took);
  endtask

  // read the outstanding count mid-cycle, after the checker has updated it
  task automatic wait_quiet();
    tick_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [CfgW-1:0] bounce, input logic [CfgW-1:0] limit);
    cfg_we   <= 1'b1;
    cfg_idx  <= RegBounce;
    cfg_data <= bounce;
    @(posedge clk_i);
    cfg_idx  <= RegLimit;
    cfg_data <= limit;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    bounce_cur = bounce;
    limit_cur  = limit;
  endtask

  // time steps cluster on the thresholds of the current setting
  function automatic logic [TimeW-1:0] next_step();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 1;
      2: return bounce_cur;
      3: return bounce_cur + 1;
      4: return limit_cur;
      5: return limit_cur + 1;
      6: return $urandom_range(0, int'(limit_cur) + 2);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_walk(input int count);
    logic [Buttons-1:0] mask;
    for (int i = 0; i < count; i++) begin
      for (int n = 0; n < Buttons; n++) begin
        if ($urandom_range(0, 3) == 0) held[n] = ~held[n];
      end
      now_t += next_step();
      mask = held;
      // sprinkle bounce noise and time jumps
      if ($urandom_range(0, 9) == 0) begin
        mask  = Buttons'($urandom_range(0, 7));
        now_t = $urandom;
      end
      send_tick(mask, now_t);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = RegBounce;
    cfg_data      = '0;
    tick_ch.valid = 1'b0;
    tick_ch.data  = '0;
    send_gaps     = 1'b1;
    recv_stalls   = 1'b1;
    hold_req      = 1'b0;
    bounce_cur    = BounceReset;
    limit_cur     = LimitReset;
    now_t         = '0;
    held          = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset setting, bounce 100 and limit 2000
    send_tick(3'b111, 32'd0);           // all arm
    send_tick(3'b111, 32'd100);         // exactly the bounce delay: still armed
    send_tick(3'b111, 32'd101);         // pressed
    send_tick(3'b111, 32'd2101);        // long press on all three
    send_tick(3'b000, 32'd2102);        // past the limit: release only
    send_tick(3'b001, 32'd3000);
    send_tick(3'b000, 32'd3050);        // armed release inside bounce: hold
    send_tick(3'b000, 32'd3101);        // armed release past bounce: idle
    send_tick(3'b111, 32'hFFFF_FFF0);
    send_tick(3'b111, 32'h0000_0060);   // elapsed across the wrap
    send_tick(3'b000, 32'h0000_07C0);   // hold equal to the limit: six events
    send_tick(3'b010, 32'd4096);
    send_tick(3'b010, 32'd4197);
    send_tick(3'b010, 32'd6096);        // hold equal to the limit: no long press
    send_tick(3'b010, 32'd6097);
    send_tick(3'b011, 32'd6098);
    send_tick(3'b000, 32'd6099);
    send_tick(3'b100, 32'd8000);
    send_tick(3'b100, 32'd8200);
    send_tick(3'b000, 32'd8000);        // time went back: release without press
    send_tick(3'b000, 32'hFFFF_FFFF);   // idle buttons stay quiet
    wait_quiet();

    apply_config(16'd0, 16'd0);
    hold_req = 1'b1;
    run_walk(30);
    wait_quiet();

    apply_config(16'hFFFF, 16'hFFFF);
    run_walk(30);
    wait_quiet();

    apply_config(16'd0, 16'hFFFF);
    run_walk(30);
    wait_quiet();

    apply_config(16'hFFFF, 16'd0);
    run_walk(30);
    wait_quiet();

    apply_config(16'($urandom_range(0, 300)), 16'($urandom_range(0, 3000)));
    run_walk(30);
    wait_quiet();

    // closing stretch without gaps or stalls
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    apply_config(16'($urandom), 16'($urandom));
    run_walk(30);
    wait_quiet();

    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
